// File: design/ccbb_pkg.sv
`default_nettype none
package ccbb_pkg;

  localparam int unsigned CLASS_SIZE = 256;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WORD_CNT   = CLASS_SIZE / WORD_W;
  localparam int unsigned IDX_W      = $clog2(WORD_CNT);

  localparam logic [7:0] DASH_BYTE = 8'h2D;
  localparam logic [7:0] TERM_BYTE = 8'h00;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_CNT - 1);

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_CHAR = 2'd1,
    PH_DASH = 2'd2
  } phase_t;

  typedef struct packed {
    logic                  load;
    logic                  bad;
    logic [CLASS_SIZE-1:0] bits;
  } snap_t;

endpackage
`default_nettype wire

// File: design/ccbb_update.sv
`default_nettype none
module ccbb_update (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  output ccbb_pkg::snap_t  snap
);
  import ccbb_pkg::*;

  logic [CLASS_SIZE-1:0] bitmap_r, bitmap_nxt;
  logic [7:0]            held_r, held_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  err_r, err_nxt;

  logic [CLASS_SIZE-1:0] span_mask;
  logic [CLASS_SIZE-1:0] held_bit;
  logic [CLASS_SIZE-1:0] dash_bit;
  logic [CLASS_SIZE-1:0] tail_bits;
  logic                  is_term;

  assign is_term  = (byte_in == TERM_BYTE);
  assign held_bit = CLASS_SIZE'(1) << held_r;
  assign dash_bit = CLASS_SIZE'(1) << DASH_BYTE;

  // inclusive range compare, one per class member
  always_comb begin
    for (int i = 0; i < CLASS_SIZE; i++) begin
      span_mask[i] = (8'(i) >= held_r) && (8'(i) <= byte_in);
    end
  end

  // members still pending when the terminator arrives
  always_comb begin
    tail_bits = '0;
    if (!err_r) begin
      unique case (phase_r)
        PH_CHAR: tail_bits = held_bit;
        PH_DASH: tail_bits = held_bit | dash_bit;
        default: tail_bits = '0;
      endcase
    end
  end

  assign snap = '{load: step && is_term, bad: err_r, bits: bitmap_r | tail_bits};

  always_comb begin
    bitmap_nxt = bitmap_r;
    held_nxt   = held_r;
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    if (step) begin
      if (is_term) begin
        bitmap_nxt = '0;
        held_nxt   = '0;
        phase_nxt  = PH_NONE;
        err_nxt    = 1'b0;
      end else if (!err_r) begin
        unique case (phase_r)
          PH_CHAR: begin
            if (byte_in == DASH_BYTE) begin
              phase_nxt = PH_DASH;
            end else begin
              bitmap_nxt = bitmap_r | held_bit;
              held_nxt   = byte_in;
            end
          end
          PH_DASH: begin
            if (held_r > byte_in) begin
              err_nxt = 1'b1;
            end else begin
              bitmap_nxt = bitmap_r | span_mask;
            end
            phase_nxt = PH_NONE;
            held_nxt  = '0;
          end
          default: begin
            held_nxt  = byte_in;
            phase_nxt = PH_CHAR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      held_r   <= '0;
      phase_r  <= PH_NONE;
      err_r    <= 1'b0;
    end else begin
      bitmap_r <= bitmap_nxt;
      held_r   <= held_nxt;
      phase_r  <= phase_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/ccbb_emit.sv
`default_nettype none
module ccbb_emit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ccbb_pkg::snap_t              snap,
  output logic                              free,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ccbb_pkg::IDX_W-1:0]        out_word_index,
  output logic [ccbb_pkg::WORD_W-1:0]       out_member_bits,
  output logic                              out_last_word,
  output logic                              out_bad_range
);
  import ccbb_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [CLASS_SIZE-1:0] bits_r;
  logic                  bad_r;
  logic                  pop;

  assign pop  = busy_r && out_ready;
  assign free = !busy_r || (out_ready && (cnt_r == LAST_IDX));

  assign out_valid       = busy_r;
  assign out_word_index  = cnt_r;
  assign out_member_bits = bits_r[{cnt_r, 6'b0} +: WORD_W];
  assign out_last_word   = (cnt_r == LAST_IDX);
  assign out_bad_range   = bad_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (snap.load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (pop) begin
      if (cnt_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // snapshot of the finished bitmap
  always_ff @(posedge clk) begin
    if (snap.load) begin
      bits_r <= snap.bits;
      bad_r  <= snap.bad;
    end
  end

endmodule
`default_nettype wire

// File: design/char_class_bitmap_builder.sv
// character-class bitmap builder
// input channel: one description byte per beat on in_desc_byte; a zero byte
//   ends the description. a byte, '-', byte gives an inclusive range
// result channel: per description, four beats of 64 bits each, word_index
//   0 to 3 in order, last_word on the fourth, bad_range on all four when a
//   reversed range was seen (the bitmap then holds only earlier members)
// a byte is registered on accept and folded into the bitmap the next cycle,
//   so one byte per cycle is taken in steady state while no terminator waits
// the terminator copies the bitmap into the output buffer and clears the
//   builder; the first word is offered after the terminator in the input
//   register loads the buffer, the rest one per cycle while out_ready is high
// the next description streams in while the words drain; only a second
//   terminator waits, until the fourth word of the previous one is taken
// out_ready low holds the current word; plain bytes keep flowing, a
//   terminator waits in the one-byte register and drops in_ready
// synchronous active-low reset clears the bitmap, held byte, error flag and
//   drops all valid flags
`default_nettype none
module char_class_bitmap_builder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_desc_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ccbb_pkg::IDX_W-1:0]         out_word_index,
  output logic [ccbb_pkg::WORD_W-1:0]        out_member_bits,
  output logic                               out_last_word,
  output logic                               out_bad_range
);
  import ccbb_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       free;
  logic       step;
  snap_t      snap;

  assign step     = in_v_r && ((in_byte_r != TERM_BYTE) || free);
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_desc_byte;
    end
  end

  ccbb_update u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .snap    (snap)
  );

  ccbb_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap            (snap),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_index  (out_word_index),
    .out_member_bits (out_member_bits),
    .out_last_word   (out_last_word),
    .out_bad_range   (out_bad_range)
  );

endmodule
`default_nettype wire

// File: bench/class_map_check.sv
module class_map_check (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [7:0]                  in_desc_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [ccbb_pkg::IDX_W-1:0]  out_word_index,
  input  wire logic [ccbb_pkg::WORD_W-1:0] out_member_bits,
  input  wire logic                        out_last_word,
  input  wire logic                        out_bad_range,
  output int unsigned                      mismatch_count,
  output int unsigned                      words_owed
);
  import ccbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] bits;
    logic              last;
    logic              bad;
  } class_word_t;

  class_word_t           owed_words[$];
  logic [CLASS_SIZE-1:0] member_map;
  logic [7:0]            held_byte;
  phase_t                held_ph;
  logic                  range_err;

  initial begin
    mismatch_count = 0;
    words_owed     = 0;
  end

  function automatic void clear_builder();
    member_map = '0;
    held_byte  = '0;
    held_ph    = PH_NONE;
    range_err  = 1'b0;
  endfunction

  // folds one accepted beat into the predicted bitmap, queues four words on a terminator
  function automatic void fold_byte(input logic [7:0] b);
    class_word_t w;
    if (b != TERM_BYTE) begin
      if (range_err) return;
      case (held_ph)
        PH_CHAR: begin
          if (b == DASH_BYTE) begin
            held_ph = PH_DASH;
          end else begin
            member_map[held_byte] = 1'b1;
            held_byte = b;
          end
        end
        PH_DASH: begin
          if (held_byte > b) begin
            range_err = 1'b1;
          end else begin
            for (int c = int'(held_byte); c <= int'(b); c++) member_map[c] = 1'b1;
          end
          held_ph   = PH_NONE;
          held_byte = '0;
        end
        default: begin
          held_byte = b;
          held_ph   = PH_CHAR;
        end
      endcase
      return;
    end
    if (!range_err) begin
      if (held_ph == PH_CHAR) begin
        member_map[held_byte] = 1'b1;
      end else if (held_ph == PH_DASH) begin
        member_map[held_byte] = 1'b1;
        member_map[DASH_BYTE] = 1'b1;
      end
    end
    for (int k = 0; k < int'(WORD_CNT); k++) begin
      w.idx  = IDX_W'(k);
      w.bits = member_map[k*WORD_W +: WORD_W];
      w.last = (IDX_W'(k) == LAST_IDX);
      w.bad  = range_err;
      owed_words.push_back(w);
    end
    clear_builder();
  endfunction

  always @(posedge clk) begin
    class_word_t exp_w;
    if (!rst_n) begin
      clear_builder();
      owed_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat, expected none, actual idx=%0d bits=%h last=%b bad=%b",
                   $time, out_word_index, out_member_bits, out_last_word, out_bad_range);
        end else begin
          exp_w = owed_words.pop_front();
          if (out_word_index !== exp_w.idx) begin
            mismatch_count++;
            $display("%0t: word_index expected %0d actual %0d",
                     $time, exp_w.idx, out_word_index);
          end
          if (out_member_bits !== exp_w.bits) begin
            mismatch_count++;
            $display("%0t: member_bits (word %0d) expected %h actual %h",
                     $time, exp_w.idx, exp_w.bits, out_member_bits);
          end
          if (out_last_word !== exp_w.last) begin
            mismatch_count++;
            $display("%0t: last_word (word %0d) expected %b actual %b",
                     $time, exp_w.idx, exp_w.last, out_last_word);
          end
          if (out_bad_range !== exp_w.bad) begin
            mismatch_count++;
            $display("%0t: bad_range (word %0d) expected %b actual %b",
                     $time, exp_w.idx, exp_w.bad, out_bad_range);
          end
        end
      end
      if (in_valid && in_ready) fold_byte(in_desc_byte);
    end
    words_owed = owed_words.size();
  end

endmodule

// File: bench/tb_char_class_bitmap_builder.sv
module tb_char_class_bitmap_builder;
  import ccbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BEATS = 70;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_desc_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_word_index;
  logic [WORD_W-1:0] out_member_bits;
  logic              out_last_word;
  logic              out_bad_range;

  int unsigned mismatch_count;
  int unsigned words_owed;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  char_class_bitmap_builder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_desc_byte   (in_desc_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_index (out_word_index),
    .out_member_bits(out_member_bits),
    .out_last_word  (out_last_word),
    .out_bad_range  (out_bad_range)
  );

  class_map_check i_class_map_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_desc_byte   (in_desc_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word_index (out_word_index),
    .out_member_bits(out_member_bits),
    .out_last_word  (out_last_word),
    .out_bad_range  (out_bad_range),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // called at a rising edge, returns at the edge that accepts the beat
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_desc_byte <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_class(inout int unsigned sent);
    logic [7:0] seq[$];
    int n_elems;
    int kind;
    int lo;
    int hi;
    n_elems = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 0);
    repeat (n_elems) begin
      kind = $urandom_range(19);
      if (kind <= 7) begin
        seq.push_back(8'($urandom_range(255, 1)));
      end else if (kind <= 14) begin
        lo = $urandom_range(255, 1);
        hi = $urandom_range(255, lo);
        seq.push_back(8'(lo));
        seq.push_back(DASH_BYTE);
        seq.push_back(8'(hi));
      end else if (kind <= 16) begin
        seq.push_back(DASH_BYTE);
      end else if (kind == 17) begin
        // reversed range
        lo = $urandom_range(255, 2);
        hi = $urandom_range(lo - 1, 1);
        seq.push_back(8'(lo));
        seq.push_back(DASH_BYTE);
        seq.push_back(8'(hi));
      end else if ($urandom_range(1) == 0) begin
        seq.push_back(8'($urandom_range(255, 1)));
        seq.push_back(DASH_BYTE);
        seq.push_back(8'hFF);
      end else begin
        seq.push_back(8'h01);
        seq.push_back(DASH_BYTE);
        seq.push_back(8'($urandom_range(255, 1)));
      end
    end
    if (seq.size() > 0 && $urandom_range(7) == 0) seq.push_back(DASH_BYTE);
    seq.push_back(TERM_BYTE);
    foreach (seq[i]) send_byte(seq[i]);
    sent += seq.size();
  endtask

  initial begin
    logic [7:0]  directed_beats[$];
    int unsigned sent;
    sent = 0;
    directed_beats = '{
      TERM_BYTE,
      8'h61, DASH_BYTE, 8'h7A, TERM_BYTE,
      8'h78, DASH_BYTE, TERM_BYTE,
      8'h71, TERM_BYTE,
      DASH_BYTE, DASH_BYTE, 8'h61, TERM_BYTE,
      8'h01, 8'h80, 8'hF0, DASH_BYTE, 8'hFF, TERM_BYTE,
      8'h7A, DASH_BYTE, 8'h61, 8'h63, TERM_BYTE
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_beats[i]) send_byte(directed_beats[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      while (sent < (ph + 1) * PHASE_BEATS) send_random_class(sent);
      // hold off until every owed word is out
      wait_drained();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
